/* rtl/fdsc_pkg.sv */
// ============================================================================
// fdsc_pkg
// Shared types and constants of the flash download session checker.
// ============================================================================
package fdsc_pkg;

    localparam int unsigned NUM_WINDOWS         = 3;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
    localparam int unsigned MAX_MSG_LEN         = 4095;
    localparam int unsigned BLOCK_OVERHEAD      = 8;
    localparam logic [11:0] MAX_BLOCK_BYTES     = 12'(MAX_MSG_LEN - BLOCK_OVERHEAD);

    // Configuration register indexes.
    localparam logic [2:0] REG_WIN0_START = 3'd0;
    localparam logic [2:0] REG_WIN0_END   = 3'd1;
    localparam logic [2:0] REG_WIN1_START = 3'd2;
    localparam logic [2:0] REG_WIN1_END   = 3'd3;
    localparam logic [2:0] REG_WIN2_START = 3'd4;
    localparam logic [2:0] REG_WIN2_END   = 3'd5;
    localparam logic [2:0] REG_BIG_ENDIAN = 3'd6;

    typedef enum logic [1:0] {
        CMD_DOWNLOAD = 2'd0,
        CMD_UPLOAD   = 2'd1,
        CMD_DATA     = 2'd2,
        CMD_EXIT     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SEQ   = 2'd2,
        ST_UNSUP = 2'd3
    } status_t;

    typedef struct packed {
        logic [NUM_WINDOWS-1:0][31:0] win_start;
        logic [NUM_WINDOWS-1:0][31:0] win_end;
    } cfg_t;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        cmd_t        command;
        logic [31:0] address;
        logic [32:0] addr_sum;     // address + length without wrap
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        window_hit;   // download request lies in some window
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* rtl/fdsc_if.sv */
// ============================================================================
// fdsc_if
// Valid/ready channels for request items and result items.
// ============================================================================
interface fdsc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] address;
    logic [11:0] length;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;

    modport source (
        output valid, command, address, length, data_byte, first_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, command, address, length, data_byte, first_byte, last_byte,
        output ready
    );
endinterface

interface fdsc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        word_valid;
    logic [31:0] word_address;
    logic [31:0] flash_word;
    logic [11:0] max_block_bytes;

    modport source (
        output valid, status, word_valid, word_address, flash_word, max_block_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, word_valid, word_address, flash_word, max_block_bytes,
        output ready
    );
endinterface

/* rtl/fdsc_front.sv */
// ============================================================================
// fdsc_front
// Accepts request items and classifies download requests against the windows.
// ============================================================================
module fdsc_front
    import fdsc_pkg::*;
(
    fdsc_req_if.sink  req,
    input  cfg_t      cfg,
    input  q_status_t q_status,
    output logic      push,
    output entry_t    push_entry
);

    logic [32:0]            addr_sum;
    logic [NUM_WINDOWS-1:0] hit;

    assign addr_sum = {1'b0, req.address} + 33'(req.length);

    // A window takes part only when both bounds are nonzero.
    always_comb
    begin
        for (int i = 0; i < NUM_WINDOWS; i++)
        begin
            hit[i] = (cfg.win_start[i] != 32'd0) && (cfg.win_end[i] != 32'd0) &&
                     (req.address >= cfg.win_start[i]) && (req.address < cfg.win_end[i]) &&
                     (addr_sum <= ({1'b0, cfg.win_end[i]} + 33'd1));
        end
    end

    assign req.ready = !q_status.full;
    assign push      = req.valid && !q_status.full;

    always_comb
    begin
        push_entry            = '0;
        push_entry.command    = cmd_t'(req.command);
        push_entry.address    = req.address;
        push_entry.addr_sum   = addr_sum;
        push_entry.data_byte  = req.data_byte;
        push_entry.first_byte = req.first_byte;
        push_entry.last_byte  = req.last_byte;
        push_entry.window_hit = |hit;
    end

endmodule

/* rtl/fdsc_queue.sv */
// ============================================================================
// fdsc_queue
// Short register queue that decouples the front from the back.
// ============================================================================
module fdsc_queue
    import fdsc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head,
    output q_status_t q_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign head           = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

endmodule

/* rtl/fdsc_back.sv */
// ============================================================================
// fdsc_back
// Session state, block checks and word packing; holds the result register.
// ============================================================================
module fdsc_back
    import fdsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      big_endian,
    input  entry_t    head,
    input  q_status_t q_status,
    output logic      pop,
    fdsc_rsp_if.source rsp
);

    logic        open_reg,     open_next;
    logic [31:0] start_reg,    start_next;
    logic [31:0] end_reg,      end_next;
    logic        rejected_reg, rejected_next;
    logic [31:0] acc_reg,      acc_next;
    logic [1:0]  pos_reg,      pos_next;
    logic [31:0] nwa_reg,      nwa_next;

    logic        out_valid_reg;
    status_t     status_reg,   status_next;
    logic        wvalid_reg,   wvalid_next;
    logic [31:0] waddr_reg,    waddr_next;
    logic [31:0] word_reg,     word_next;
    logic [11:0] maxblk_reg;

    logic        take;
    logic [31:0] acc_base;
    logic [1:0]  pos_base;
    logic [31:0] nwa_base;
    logic [1:0]  lane;
    logic [31:0] acc_new;
    logic        range_bad;

    assign pop = !q_status.empty && (!out_valid_reg || rsp.ready);

    assign range_bad = (head.address < start_reg) ||
                       (head.addr_sum > ({1'b0, end_reg} + 33'd1));

    always_comb
    begin
        open_next     = open_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        rejected_next = rejected_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        nwa_next      = nwa_reg;
        status_next   = ST_OK;
        wvalid_next   = 1'b0;
        waddr_next    = 32'd0;
        word_next     = 32'd0;
        take          = 1'b0;
        acc_base      = acc_reg;
        pos_base      = pos_reg;
        nwa_base      = nwa_reg;
        lane          = 2'd0;
        acc_new       = 32'd0;

        unique case (head.command)
            CMD_DOWNLOAD:
            begin
                if (head.window_hit)
                begin
                    start_next    = head.address;
                    end_next      = head.addr_sum[31:0] - 32'd1;
                    open_next     = 1'b1;
                    rejected_next = 1'b0;
                    acc_next      = 32'd0;
                    pos_next      = 2'd0;
                end
                else
                begin
                    open_next   = 1'b0;
                    status_next = ST_RANGE;
                end
            end
            CMD_UPLOAD:
            begin
                status_next = ST_UNSUP;
            end
            CMD_DATA:
            begin
                take = 1'b1;
                if (head.first_byte)
                begin
                    if (!open_reg || (start_reg == 32'd0) || (end_reg == 32'd0))
                    begin
                        status_next = ST_SEQ;
                        take        = 1'b0;
                    end
                    else if (range_bad)
                    begin
                        status_next = ST_RANGE;
                        take        = 1'b0;
                    end
                    rejected_next = !take;
                    if (take)
                    begin
                        acc_base = 32'd0;
                        pos_base = 2'd0;
                        nwa_base = head.address;
                    end
                end
                else if (rejected_reg || !open_reg)
                begin
                    status_next = ST_SEQ;
                    take        = 1'b0;
                end

                if (take)
                begin
                    lane    = big_endian ? ~pos_base : pos_base;
                    acc_new = acc_base;
                    acc_new[lane*8 +: 8] = acc_base[lane*8 +: 8] | head.data_byte;
                    if ((pos_base == 2'd3) || head.last_byte)
                    begin
                        wvalid_next = 1'b1;
                        waddr_next  = nwa_base;
                        word_next   = acc_new;
                        nwa_next    = nwa_base + 32'd4;
                        acc_next    = 32'd0;
                        pos_next    = 2'd0;
                    end
                    else
                    begin
                        acc_next = acc_new;
                        pos_next = pos_base + 2'd1;
                        nwa_next = nwa_base;
                    end
                end
            end
            CMD_EXIT:
            begin
                if ((head.address != 32'd0) && (head.address != start_reg))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    start_next    = 32'd0;
                    end_next      = 32'd0;
                    open_next     = 1'b0;
                    rejected_next = 1'b0;
                    acc_next      = 32'd0;
                    pos_next      = 2'd0;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            start_reg     <= 32'd0;
            end_reg       <= 32'd0;
            rejected_reg  <= 1'b0;
            acc_reg       <= 32'd0;
            pos_reg       <= 2'd0;
            nwa_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                open_reg     <= open_next;
                start_reg    <= start_next;
                end_reg      <= end_next;
                rejected_reg <= rejected_next;
                acc_reg      <= acc_next;
                pos_reg      <= pos_next;
                nwa_reg      <= nwa_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            wvalid_reg <= wvalid_next;
            waddr_reg  <= waddr_next;
            word_reg   <= word_next;
            maxblk_reg <= open_next ? MAX_BLOCK_BYTES : 12'd0;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.word_valid      = wvalid_reg;
    assign rsp.word_address    = waddr_reg;
    assign rsp.flash_word      = word_reg;
    assign rsp.max_block_bytes = maxblk_reg;

    a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && wvalid_reg) |-> (status_reg == ST_OK))
        else $error("word emitted with an error status");

endmodule

/* rtl/flash_download_session_checker_top.sv */
// ============================================================================
// flash_download_session_checker_top
// Checks a flash download session and packs its payload into flash words.
// ============================================================================
// The block takes one item per clock cycle while its queue is not full and
// returns exactly one result item for each, in order. An accepted item is
// classified by the front (the three core window compares for a download
// request), waits in a short register queue, and is carried out by the back,
// which owns the session state and registers the result. With no stall an
// accepted item goes into a queue slot and is popped from there by the back.
// The queue lets the input keep flowing for QUEUE_DEPTH items while the
// result side is stalled, and a result that waits to be taken does not stop
// the next item from being accepted. The sustained rate is one item per cycle
// while results are taken, bounded by the single session update in the back.
// Configuration registers must only be written while no item is in flight.
module flash_download_session_checker_top
    import fdsc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    fdsc_req_if.sink    req,
    fdsc_rsp_if.source  rsp
);

    // Configuration registers. The windows feed the front's compares, the
    // byte order selects the lane in the back's word packer.
    cfg_t      cfg_reg;
    logic      big_endian_reg;

    // Handoff between front, queue and back.
    logic      push;
    entry_t    push_entry;
    logic      pop;
    entry_t    head;
    q_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            big_endian_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIN0_START: cfg_reg.win_start[0] <= cfg_data;
                REG_WIN0_END:   cfg_reg.win_end[0]   <= cfg_data;
                REG_WIN1_START: cfg_reg.win_start[1] <= cfg_data;
                REG_WIN1_END:   cfg_reg.win_end[1]   <= cfg_data;
                REG_WIN2_START: cfg_reg.win_start[2] <= cfg_data;
                REG_WIN2_END:   cfg_reg.win_end[2]   <= cfg_data;
                REG_BIG_ENDIAN: big_endian_reg       <= cfg_data[0];
                default:        big_endian_reg       <= big_endian_reg;
            endcase
        end
    end

    // The front decides window membership while the item is accepted.
    fdsc_front u_front (
        .req        (req),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    fdsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    // The back pops one item whenever its result register is free or drains.
    fdsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .big_endian (big_endian_reg),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

/* tb/sv/tb.sv */
// ============================================================================
// tb
// Self-checking bench for the flash download session checker.
// ============================================================================
// Items are driven on the request channel and results are taken from the
// response channel. Both sides may wait a random number of cycles before each item.
// A session model predicts one result per accepted item. Every
// result is compared field by field with the oldest prediction. Directed items
// cover the corner cases first. Random sessions then run under several window
// and byte-order settings.
module tb;
    import fdsc_pkg::*;

    // Cycle budget for the whole run: ample for the 660 or more items, each
    // with its random waits on each side plus the pipeline.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Register indexes of the window bounds, by window number.
    localparam logic [2:0] START_REG [NUM_WINDOWS] =
        '{REG_WIN0_START, REG_WIN1_START, REG_WIN2_START};
    localparam logic [2:0] END_REG [NUM_WINDOWS] =
        '{REG_WIN0_END, REG_WIN1_END, REG_WIN2_END};

    typedef struct {
        status_t     status;
        logic        word_valid;
        logic [31:0] word_address;
        logic [31:0] flash_word;
        logic [11:0] max_block_bytes;
    } session_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    fdsc_req_if req_ch ();
    fdsc_rsp_if rsp_ch ();

    flash_download_session_checker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Mirror of the configuration registers.
    logic [31:0] win_lo [NUM_WINDOWS];
    logic [31:0] win_hi [NUM_WINDOWS];
    logic        big_first;

    // Mirror of the session state and of the word packer.
    logic        sess_open;
    logic [31:0] sess_start;
    logic [31:0] sess_end;
    logic        blk_rejected;
    logic [31:0] word_acc;
    int unsigned byte_pos;
    logic [31:0] next_waddr;

    // Results the block still owes us, oldest first.
    session_result_t session_results_due [$];

    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned cycle_count;

    // When clear, the matching side runs back to back with no waits.
    bit send_idle;
    bit recv_idle;

    always #6 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Works out the result of one accepted item and moves the session
    // state on, exactly as the block is specified to do.
    function automatic session_result_t advance_session(
        input cmd_t        cmd,
        input logic [31:0] addr,
        input logic [11:0] len,
        input logic [7:0]  data,
        input logic        first,
        input logic        last
    );
        session_result_t r;
        logic            hit;
        logic            take;
        int unsigned     i;

        r.status       = ST_OK;
        r.word_valid   = 1'b0;
        r.word_address = '0;
        r.flash_word   = '0;
        case (cmd)
            CMD_DOWNLOAD:
            begin
                hit = 1'b0;
                for (i = 0; i < NUM_WINDOWS; i++)
                begin
                    // A window with either bound at zero is switched off.
                    if (win_lo[i] != 0 && win_hi[i] != 0 && addr >= win_lo[i] &&
                        addr < win_hi[i] &&
                        {1'b0, addr} + 33'(len) <= {1'b0, win_hi[i]} + 33'd1)
                        hit = 1'b1;
                end
                if (hit)
                begin
                    sess_start   = addr;
                    sess_end     = addr + 32'(len) - 32'd1;
                    sess_open    = 1'b1;
                    blk_rejected = 1'b0;
                    word_acc     = '0;
                    byte_pos     = 0;
                end
                else
                begin
                    sess_open = 1'b0;
                    r.status  = ST_RANGE;
                end
            end
            CMD_UPLOAD:
                r.status = ST_UNSUP;
            CMD_DATA:
            begin
                take = 1'b1;
                if (first)
                begin
                    if (!sess_open || sess_start == 0 || sess_end == 0)
                    begin
                        r.status = ST_SEQ;
                        take     = 1'b0;
                    end
                    else if (addr < sess_start ||
                             {1'b0, addr} + 33'(len) > {1'b0, sess_end} + 33'd1)
                    begin
                        r.status = ST_RANGE;
                        take     = 1'b0;
                    end
                    blk_rejected = !take;
                    if (take)
                    begin
                        word_acc   = '0;
                        byte_pos   = 0;
                        next_waddr = addr;
                    end
                end
                else if (blk_rejected || !sess_open)
                begin
                    r.status = ST_SEQ;
                    take     = 1'b0;
                end
                if (take)
                begin
                    word_acc |= 32'(data) << (big_first ? 8 * (3 - byte_pos) : 8 * byte_pos);
                    byte_pos++;
                    if (byte_pos >= 4 || last)
                    begin
                        r.word_valid   = 1'b1;
                        r.word_address = next_waddr;
                        r.flash_word   = word_acc;
                        next_waddr     = next_waddr + 32'd4;
                        word_acc       = '0;
                        byte_pos       = 0;
                    end
                end
            end
            CMD_EXIT:
            begin
                if (addr != 0 && addr != sess_start)
                    r.status = ST_RANGE;
                else
                begin
                    // Closing drops any partly filled word.
                    sess_start   = '0;
                    sess_end     = '0;
                    sess_open    = 1'b0;
                    blk_rejected = 1'b0;
                    word_acc     = '0;
                    byte_pos     = 0;
                end
            end
        endcase
        r.max_block_bytes = sess_open ? MAX_BLOCK_BYTES : 12'd0;
        return r;
    endfunction

    task automatic report_mismatch(
        input string           what,
        input session_result_t want,
        input session_result_t got
    );
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected status=%0d word_valid=%0b word_address=%h flash_word=%h max_block_bytes=%0d, got status=%0d word_valid=%0b word_address=%h flash_word=%h max_block_bytes=%0d",
                     what, want.status, want.word_valid, want.word_address,
                     want.flash_word, want.max_block_bytes, got.status, got.word_valid,
                     got.word_address, got.flash_word, got.max_block_bytes);
    endtask

    // Every result taken from the block is checked against the oldest
    // prediction. A result that arrives with nothing owed is an error too.
    always @(posedge clk)
    begin : check_result
        session_result_t want;
        session_result_t got;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status          = status_t'(rsp_ch.status);
            got.word_valid      = rsp_ch.word_valid;
            got.word_address    = rsp_ch.word_address;
            got.flash_word      = rsp_ch.flash_word;
            got.max_block_bytes = rsp_ch.max_block_bytes;
            if (session_results_due.size() == 0)
            begin
                want = '{ST_OK, 1'b0, 32'd0, 32'd0, 12'd0};
                report_mismatch("result item with nothing outstanding", want, got);
            end
            else
            begin
                want = session_results_due.pop_front();
                if (got.status !== want.status || got.word_valid !== want.word_valid ||
                    got.word_address !== want.word_address ||
                    got.flash_word !== want.flash_word ||
                    got.max_block_bytes !== want.max_block_bytes)
                    report_mismatch("result item differs", want, got);
            end
        end
    end

    // Result side: before each result it may hold ready low for a random
    // number of cycles, then keeps it high until a result item is taken.
    initial
    begin : drain_results
        int unsigned stall;

        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = recv_idle ? $urandom_range(0, 18) : 0;
            if (stall != 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    // Sends one item after a random gap and records what it must produce.
    // With no gap, valid simply stays high and the fields move on.
    task automatic send_item(
        input cmd_t        cmd,
        input logic [31:0] addr,
        input logic [11:0] len,
        input logic [7:0]  data,
        input logic        first,
        input logic        last
    );
        int unsigned gap;

        gap = send_idle ? $urandom_range(0, 18) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.command    = cmd;
        req_ch.address    = addr;
        req_ch.length     = len;
        req_ch.data_byte  = data;
        req_ch.first_byte = first;
        req_ch.last_byte  = last;
        req_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        session_results_due.push_back(advance_session(cmd, addr, len, data, first, last));
        items_sent++;
    endtask

    // Stops sending and waits until every owed result has come back, then
    // gives the pipeline time to empty.
    task automatic wait_for_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (session_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_WIN0_START: win_lo[0] = value;
            REG_WIN0_END:   win_hi[0] = value;
            REG_WIN1_START: win_lo[1] = value;
            REG_WIN1_END:   win_hi[1] = value;
            REG_WIN2_START: win_lo[2] = value;
            REG_WIN2_END:   win_hi[2] = value;
            REG_BIG_ENDIAN: big_first = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_windows(
        input logic [31:0] lo0, input logic [31:0] hi0,
        input logic [31:0] lo1, input logic [31:0] hi1,
        input logic [31:0] lo2, input logic [31:0] hi2
    );
        write_register(REG_WIN0_START, lo0);
        write_register(REG_WIN0_END, hi0);
        write_register(REG_WIN1_START, lo1);
        write_register(REG_WIN1_END, hi1);
        write_register(REG_WIN2_START, lo2);
        write_register(REG_WIN2_END, hi2);
    endtask

    // Three enabled windows of up to about 6000 bytes at random places.
    task automatic set_random_windows();
        int unsigned i;
        logic [31:0] lo;

        for (i = 0; i < NUM_WINDOWS; i++)
        begin
            lo = $urandom_range(1, 32'hFFFF_0000);
            write_register(START_REG[i], lo);
            write_register(END_REG[i], lo + $urandom_range(1, 6000));
        end
    endtask

    // A download request, mostly one that lands in an enabled window: near
    // either end of it, with lengths from zero up to one byte too many.
    task automatic run_download();
        int unsigned       enabled [$];
        int unsigned       i;
        int unsigned       w;
        int unsigned       reach;
        logic [31:0]       a;
        logic [11:0]       len;
        longint unsigned   room;
        longint unsigned   cap;

        for (i = 0; i < NUM_WINDOWS; i++)
            if (win_lo[i] != 0 && win_hi[i] != 0 && win_lo[i] < win_hi[i])
                enabled.push_back(i);
        if (enabled.size() != 0 && $urandom_range(0, 7) != 0)
        begin
            w     = enabled[$urandom_range(0, enabled.size() - 1)];
            room  = 64'(win_hi[w]) - 64'(win_lo[w]);
            reach = (room > 64) ? 64 : int'(room);
            if ($urandom_range(0, 1))
                a = win_lo[w] + $urandom_range(0, reach - 1);
            else
                a = win_hi[w] - $urandom_range(1, reach);
            cap = 64'(win_hi[w]) + 64'd1 - 64'(a);
            case ($urandom_range(0, 9))
                0: len = (cap > 4095) ? 12'd4095 : 12'(cap);
                1: len = (cap < 4095) ? 12'(cap + 1) : 12'd4095;
                2: len = 12'd0;
                default: len = 12'($urandom_range(1, (cap > 48) ? 48 : int'(cap)));
            endcase
        end
        else
        begin
            a   = $urandom;
            len = 12'($urandom_range(0, 4095));
        end
        send_item(CMD_DOWNLOAD, a, len, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // One transfer block: usually inside the open session, sometimes below
    // its start, past its end, or with no session at all. Now and then the
    // closing byte carries no last mark, so a partial word is left pending.
    task automatic run_block();
        logic [31:0]     b;
        longint unsigned span;
        int unsigned     off;
        int unsigned     blen;
        int unsigned     k;
        bit              mark_last;

        span = (sess_end >= sess_start) ? 64'(sess_end) - 64'(sess_start) + 64'd1 : 64'd0;
        if (sess_open && span != 0 && $urandom_range(0, 7) != 0)
        begin
            off  = $urandom_range(0, (span > 32) ? 32 : int'(span) - 1);
            b    = sess_start + off;
            blen = $urandom_range(1, (span - off > 12) ? 12 : int'(span - off));
            if ($urandom_range(0, 9) == 0)
                blen++;
        end
        else if (sess_open && $urandom_range(0, 1))
        begin
            b    = sess_start - 32'd1;
            blen = $urandom_range(1, 8);
        end
        else
        begin
            b    = $urandom;
            blen = $urandom_range(1, 12);
        end
        mark_last = ($urandom_range(0, 9) != 0);
        for (k = 0; k < blen; k++)
            send_item(CMD_DATA, (k == 0) ? b : 32'($urandom),
                      (k == 0) ? 12'(blen) : 12'($urandom), 8'($urandom),
                      k == 0, mark_last && k == blen - 1);
    endtask

    task automatic run_noise(input int unsigned n);
        repeat (n)
            send_item(cmd_t'(2'($urandom)), $urandom, 12'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom));
    endtask

    // A whole session: download, a few blocks, then mostly an exit.
    task automatic run_session();
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        run_download();
        repeat ($urandom_range(1, 3)) run_block();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_item(CMD_EXIT, sess_start, 12'($urandom), 8'($urandom), 0, 0);
            5, 6:          send_item(CMD_EXIT, 32'd0, 12'($urandom), 8'($urandom), 0, 0);
            7:             send_item(CMD_EXIT, $urandom, 12'($urandom), 8'($urandom), 0, 0);
            8:             send_item(CMD_UPLOAD, $urandom, 12'($urandom), 8'($urandom), 0, 0);
            default: ;
        endcase
        if ($urandom_range(0, 5) == 0)
            run_noise($urandom_range(1, 3));
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned stop;

        stop = items_sent + n;
        while (items_sent < stop)
            run_session();
    endtask

    // Corner cases one by one: everything refused before any window is set,
    // then packing, range and sequence errors, exits, and the address extremes.
    task automatic test_directed();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        // No window enabled yet: the download is refused, data has no session.
        send_item(CMD_DOWNLOAD, 32'h0000_1000, 12'd16, 8'h00, 0, 0);
        send_item(CMD_DATA, 32'h0000_1000, 12'd4, 8'hA5, 1, 0);
        send_item(CMD_DATA, 32'h0000_0000, 12'd0, 8'h5A, 0, 1);
        send_item(CMD_UPLOAD, 32'hFFFF_FFFF, 12'hFFF, 8'hFF, 1, 1);
        send_item(CMD_EXIT, 32'd0, 12'd0, 8'h00, 0, 0);
        wait_for_idle();
        set_windows(32'h0000_1000, 32'h0000_2000, 32'hFFFF_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h0000_0100);
        write_register(REG_BIG_ENDIAN, 32'd1);
        // Six bytes give one full word and one zero-padded partial word.
        send_item(CMD_DOWNLOAD, 32'h0000_1000, 12'd16, 8'h00, 0, 0);
        send_item(CMD_DATA, 32'h0000_1000, 12'd6, 8'h11, 1, 0);
        send_item(CMD_DATA, 32'h0000_0000, 12'd0, 8'h22, 0, 0);
        send_item(CMD_DATA, 32'h0000_0000, 12'd0, 8'h33, 0, 0);
        send_item(CMD_DATA, 32'h0000_0000, 12'd0, 8'h44, 0, 0);
        send_item(CMD_DATA, 32'h0000_0000, 12'd0, 8'h55, 0, 0);
        send_item(CMD_DATA, 32'h0000_0000, 12'd0, 8'h66, 0, 1);
        // Block below the session start, then a byte of that rejected block.
        send_item(CMD_DATA, 32'h0000_0FFF, 12'd2, 8'h77, 1, 0);
        send_item(CMD_DATA, 32'h0000_0000, 12'd0, 8'h88, 0, 1);
        // Block that runs one byte past the session end.
        send_item(CMD_DATA, 32'h0000_100C, 12'd5, 8'h99, 1, 0);
        // Exit at an address that is neither zero nor the session start.
        send_item(CMD_EXIT, 32'h0000_1004, 12'd0, 8'h00, 0, 0);
        // A pending partial word is dropped by an exit at address zero.
        send_item(CMD_DATA, 32'h0000_100C, 12'd4, 8'hAB, 1, 0);
        send_item(CMD_EXIT, 32'd0, 12'd0, 8'h00, 0, 0);
        // Session ending at the very top of the address space, and a request
        // at the window end address itself.
        send_item(CMD_DOWNLOAD, 32'hFFFF_FFF0, 12'd16, 8'h00, 0, 0);
        send_item(CMD_DOWNLOAD, 32'hFFFF_FFFF, 12'd0, 8'h00, 0, 0);
        // Zero-length download at address one leaves the session end at zero.
        send_item(CMD_DOWNLOAD, 32'h0000_0001, 12'd0, 8'h00, 0, 0);
        send_item(CMD_DATA, 32'h0000_0001, 12'd0, 8'hC3, 1, 1);
        send_item(CMD_DOWNLOAD, 32'h0000_0000, 12'd0, 8'h00, 0, 0);
    endtask

    // The sender stops more than once until every result is back.
    task automatic test_sender_pause();
        wait_for_idle();
        set_random_windows();
        write_register(REG_BIG_ENDIAN, 32'd1);
        repeat (3)
        begin
            run_phase(40);
            wait_for_idle();
        end
    endtask

    // Little-endian packing with one window off by its start and one by its end.
    task automatic test_little_endian();
        logic [31:0] lo;

        wait_for_idle();
        lo = $urandom_range(1, 32'hFFFF_0000);
        set_windows(32'd0, $urandom_range(1, 32'hFFFF_FFFF), lo, lo + $urandom_range(64, 6000),
                    $urandom_range(1, 32'hFFFF_FFFF), 32'd0);
        write_register(REG_BIG_ENDIAN, 32'd0);
        run_phase(120);
    endtask

    // One window spanning the address space from one to the top; one that can hold nothing.
    task automatic test_full_address_range();
        wait_for_idle();
        set_windows(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'd0, 32'd0);
        write_register(REG_BIG_ENDIAN, 32'd1);
        run_phase(120);
    endtask

    // Every window off: all downloads are refused.
    task automatic test_no_windows();
        wait_for_idle();
        set_windows(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_phase(40);
    endtask

    // Fresh random windows and byte order a few times over.
    task automatic test_mixed_settings();
        repeat (3)
        begin
            wait_for_idle();
            set_random_windows();
            write_register(REG_BIG_ENDIAN, 32'($urandom_range(0, 1)));
            run_phase(80);
        end
    endtask

    initial
    begin : main
        int unsigned i;

        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_WIN0_START;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_DOWNLOAD;
        req_ch.address    = '0;
        req_ch.length     = '0;
        req_ch.data_byte  = '0;
        req_ch.first_byte = 1'b0;
        req_ch.last_byte  = 1'b0;
        for (i = 0; i < NUM_WINDOWS; i++)
        begin
            win_lo[i] = '0;
            win_hi[i] = '0;
        end
        big_first      = 1'b1;
        sess_open      = 1'b0;
        sess_start     = '0;
        sess_end       = '0;
        blk_rejected   = 1'b0;
        word_acc       = '0;
        byte_pos       = 0;
        next_waddr     = '0;
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        send_idle      = 1'b1;
        recv_idle      = 1'b1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_sender_pause();
        test_little_endian();
        test_full_address_range();
        test_no_windows();
        test_mixed_settings();

        // Let the last results come back and give the pipeline time to show
        // any stray result before the verdict.
        wait_for_idle();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
